[rtl/atas_pkg.sv]
// Shared types, constants and functions of the additive tone ADSR synthesiser.
// No dependencies; every other file except atas_if refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package atas_pkg;

    localparam int APB_ADDR_W   = 6;
    localparam int APB_DATA_W   = 64;
    localparam int PHASE_MAX_W  = 32;
    localparam int LEVEL_W      = 17;
    localparam int GAIN_W       = 16;
    localparam int ACC_W        = 33;
    localparam int PROD_W       = ACC_W + LEVEL_W + 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int FRAC_SHIFT   = 31;

    localparam logic [LEVEL_W-1:0] UNITY = 17'h10000;

    localparam logic [2:0] REG_GAINS       = 3'd0;
    localparam logic [2:0] REG_ATTACK      = 3'd1;
    localparam logic [2:0] REG_DECAY       = 3'd2;
    localparam logic [2:0] REG_SUSTAIN     = 3'd3;
    localparam logic [2:0] REG_REL_FRAMES  = 3'd4;
    localparam logic [2:0] REG_REL_STEP    = 3'd5;

    localparam logic [63:0]        GAINS_RST      = 64'h0571_0C3D_17CD_4400;
    localparam logic [LEVEL_W-1:0] ATTACK_RST     = 17'd149;
    localparam logic [LEVEL_W-1:0] DECAY_RST      = 17'd6;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST    = 17'd52429;
    localparam logic [15:0]        REL_FRAMES_RST = 16'd3528;
    localparam logic [LEVEL_W-1:0] REL_STEP_RST   = 17'd15;

    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [2:0] {
        ENV_IDLE    = 3'd0,
        ENV_ATTACK  = 3'd1,
        ENV_DECAY   = 3'd2,
        ENV_SUSTAIN = 3'd3,
        ENV_RELEASE = 3'd4
    } t_env_stage;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_MUL,
        BK_FIN
    } t_back_state;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack;
        logic [LEVEL_W-1:0] decay;
        logic [LEVEL_W-1:0] sustain;
        logic [15:0]        rel_frames;
        logic [LEVEL_W-1:0] rel_step;
    } t_env_cfg;

    typedef struct packed {
        logic [PHASE_MAX_W-1:0] phase;
        logic [LEVEL_W-1:0]     level;
        logic                   active;
        logic                   last;
    } t_job;

    function automatic logic [LEVEL_W-1:0] clamp_unity(input logic [LEVEL_W-1:0] v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    // Quarter-wave sine magnitude, degree-9 Taylor polynomial in unsigned Q30
    function automatic logic [14:0] sine_mag(input logic [12:0] j, input logic [3:0] log2d);
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] s;
        logic [63:0] v;
        m  = 64'(j) << (7'd32 - 7'(log2d));
        a  = (m * TWO_PI_Q30) >> 32;
        a2 = (a * a) >> 30;
        s  = Q30_ONE - a2 / 64'd72;
        s  = Q30_ONE - ((a2 * s) >> 30) / 64'd42;
        s  = Q30_ONE - ((a2 * s) >> 30) / 64'd20;
        s  = Q30_ONE - ((a2 * s) >> 30) / 64'd6;
        v  = (a * s) >> 30;
        v  = (v * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

`default_nettype wire

[rtl/atas_if.sv]
// Stream interfaces of the synthesiser: note command in, PCM sample out.
// Independent of the package; valid/ready handshake on both.
`timescale 1ns / 1ps
`default_nettype none

interface atas_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [23:0] phase_step;
    logic [15:0] note_frames;

    modport source (output valid, action, phase_step, note_frames, input ready);
    modport sink (input valid, action, phase_step, note_frames, output ready);
endinterface

interface atas_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               note_last;
    logic               silent;

    modport source (output valid, sample, note_last, silent, input ready);
    modport sink (input valid, sample, note_last, silent, output ready);
endinterface

`default_nettype wire

[rtl/additive_tone_adsr_synth.sv]
// Additive tone synthesiser with ADSR envelope: top level, APB register file,
// front end, job queue and sample engine. Uses atas_pkg, atas_if and all atas_* modules.
//
// i_in carries one command transaction per sample frame: action 1 starts a
// note (latching phase_step and note_frames), action 0 advances one frame.
// o_out returns exactly one PCM sample transaction per command: sample,
// note_last on the final frame of a note, silent past the note end.
// The front end accepts a command while the two-entry queue has room. The
// sample engine works one harmonic per cycle on its shared 16x16 multiplier,
// then does the envelope multiply, then saturates into the output register;
// it takes the next job only once the previous sample is loaded there.
// A stalled receiver holds the output register; the engine then waits and
// the queue fills, after which i_in.ready drops. Reset returns the note to
// silence, clears the queue and restores the register defaults; the sine
// table is constant and needs no fill. Registers sit at 8*index; the user
// must write them only while no command is outstanding, which the block
// itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module additive_tone_adsr_synth #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int HARMONIC_COUNT   = 4,
    parameter int PHASE_BITS       = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    atas_in_if.sink                                 i_in,
    atas_out_if.source                              o_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [atas_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [atas_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [atas_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    logic [63:0]                  r_gains;
    logic [atas_pkg::LEVEL_W-1:0] r_attack, r_decay, r_sustain, r_rel_step;
    logic [15:0]                  r_rel_frames;

    logic [2:0]         w_reg_idx;
    logic               w_wr;
    atas_pkg::t_env_cfg w_cfg;
    atas_pkg::t_job     w_push_job, w_head_job;
    logic               w_push, w_pop, w_full, w_empty;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[5:3];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains      <= atas_pkg::GAINS_RST;
            r_attack     <= atas_pkg::ATTACK_RST;
            r_decay      <= atas_pkg::DECAY_RST;
            r_sustain    <= atas_pkg::SUSTAIN_RST;
            r_rel_frames <= atas_pkg::REL_FRAMES_RST;
            r_rel_step   <= atas_pkg::REL_STEP_RST;
        end else if (w_wr) begin
            case (w_reg_idx)
                atas_pkg::REG_GAINS:      r_gains      <= pwdata;
                atas_pkg::REG_ATTACK:     r_attack     <= pwdata[atas_pkg::LEVEL_W-1:0];
                atas_pkg::REG_DECAY:      r_decay      <= pwdata[atas_pkg::LEVEL_W-1:0];
                atas_pkg::REG_SUSTAIN:    r_sustain    <= pwdata[atas_pkg::LEVEL_W-1:0];
                atas_pkg::REG_REL_FRAMES: r_rel_frames <= pwdata[15:0];
                atas_pkg::REG_REL_STEP:   r_rel_step   <= pwdata[atas_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            atas_pkg::REG_GAINS:      prdata = r_gains;
            atas_pkg::REG_ATTACK:     prdata = 64'(r_attack);
            atas_pkg::REG_DECAY:      prdata = 64'(r_decay);
            atas_pkg::REG_SUSTAIN:    prdata = 64'(r_sustain);
            atas_pkg::REG_REL_FRAMES: prdata = 64'(r_rel_frames);
            atas_pkg::REG_REL_STEP:   prdata = 64'(r_rel_step);
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg.attack     = r_attack;
        w_cfg.decay      = r_decay;
        w_cfg.sustain    = r_sustain;
        w_cfg.rel_frames = r_rel_frames;
        w_cfg.rel_step   = r_rel_step;
    end

    atas_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (w_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    atas_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    atas_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .HARMONIC_COUNT   (HARMONIC_COUNT),
        .PHASE_BITS       (PHASE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gains (r_gains),
        .i_job   (w_head_job),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[rtl/atas_front.sv]
// Front end: accepts note commands, keeps phase, frame count and ADSR envelope.
// Emits one sample job per transaction into the queue. Uses atas_pkg, atas_if.
`timescale 1ns / 1ps
`default_nettype none

module atas_front #(
    parameter int PHASE_BITS = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    atas_in_if.sink                i_in,
    input  wire atas_pkg::t_env_cfg i_cfg,
    input  wire logic              i_full,
    output logic                   o_push,
    output atas_pkg::t_job         o_job
);

    logic [PHASE_BITS-1:0]        r_phase, n_phase;
    logic [PHASE_BITS-1:0]        r_step, n_step;
    logic [15:0]                  r_fi, n_fi;
    logic [15:0]                  r_len, n_len;
    atas_pkg::t_env_stage         r_stage, n_stage;
    logic [atas_pkg::LEVEL_W-1:0] r_lvl, n_lvl;

    logic [PHASE_BITS-1:0]        w_ph;
    logic [15:0]                  w_fi;
    logic [atas_pkg::LEVEL_W-1:0] w_lvl;
    atas_pkg::t_env_stage         w_stage;
    logic                         w_active;
    logic [16:0]                  w_fi_next;
    logic [15:0]                  w_rel_start;
    logic [atas_pkg::LEVEL_W-1:0] w_att, w_dec, w_sus, w_rel;
    logic [17:0]                  w_sum;
    logic                         w_accept;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign o_push     = w_accept;

    always_comb begin
        w_att = atas_pkg::clamp_unity(i_cfg.attack);
        w_dec = atas_pkg::clamp_unity(i_cfg.decay);
        w_sus = atas_pkg::clamp_unity(i_cfg.sustain);
        w_rel = atas_pkg::clamp_unity(i_cfg.rel_step);

        n_step = r_step;
        n_len  = r_len;
        w_ph   = r_phase;
        w_fi   = r_fi;
        w_lvl  = r_lvl;
        w_stage = r_stage;
        if (i_in.action) begin
            n_step  = PHASE_BITS'(i_in.phase_step);
            n_len   = i_in.note_frames;
            w_ph    = '0;
            w_fi    = '0;
            w_lvl   = '0;
            w_stage = atas_pkg::ENV_ATTACK;
        end

        w_active    = w_fi < n_len;
        w_fi_next   = {1'b0, w_fi} + 17'd1;
        w_rel_start = (n_len > i_cfg.rel_frames) ? n_len - i_cfg.rel_frames : 16'd0;
        w_sum       = '0;

        o_job        = '0;
        o_job.phase  = atas_pkg::PHASE_MAX_W'(w_ph);
        o_job.level  = w_lvl;
        o_job.active = w_active;
        o_job.last   = w_active && (w_fi_next == {1'b0, n_len});

        n_phase = w_ph + n_step;
        n_fi    = w_fi;
        n_lvl   = w_lvl;
        n_stage = w_stage;
        if (w_active) begin
            n_fi = w_fi_next[15:0];
            case (w_stage)
                atas_pkg::ENV_ATTACK: begin
                    w_sum = {1'b0, w_lvl} + {1'b0, w_att};
                    if (w_sum >= {1'b0, atas_pkg::UNITY}) begin
                        n_lvl   = atas_pkg::UNITY;
                        n_stage = atas_pkg::ENV_DECAY;
                    end else begin
                        n_lvl = w_sum[atas_pkg::LEVEL_W-1:0];
                    end
                end
                atas_pkg::ENV_DECAY: begin
                    w_sum = {1'b0, w_sus} + {1'b0, w_dec};
                    if ({1'b0, w_lvl} <= w_sum) begin
                        n_lvl   = w_sus;
                        n_stage = atas_pkg::ENV_SUSTAIN;
                    end else begin
                        n_lvl = w_lvl - w_dec;
                    end
                end
                atas_pkg::ENV_SUSTAIN: begin
                    n_lvl = w_sus;
                end
                atas_pkg::ENV_RELEASE: begin
                    n_lvl = (w_lvl > w_rel) ? w_lvl - w_rel : '0;
                end
                default: begin
                    n_lvl = w_lvl;
                end
            endcase
            if (n_stage inside {atas_pkg::ENV_ATTACK, atas_pkg::ENV_DECAY,
                                atas_pkg::ENV_SUSTAIN}
                && (w_fi_next >= {1'b0, w_rel_start})) begin
                n_stage = atas_pkg::ENV_RELEASE;
            end
            if (w_fi_next >= {1'b0, n_len}) begin
                n_stage = atas_pkg::ENV_IDLE;
                n_lvl   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_step  <= '0;
            r_fi    <= '0;
            r_len   <= '0;
            r_stage <= atas_pkg::ENV_IDLE;
            r_lvl   <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_fi    <= n_fi;
            r_len   <= n_len;
            r_stage <= n_stage;
            r_lvl   <= n_lvl;
        end
    end

endmodule

`default_nettype wire

[rtl/atas_fifo.sv]
// Two-entry job queue between front end and sample engine.
// Uses atas_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module atas_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire atas_pkg::t_job i_job,
    input  wire logic           i_pop,
    output atas_pkg::t_job      o_job,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PTR_W = $clog2(atas_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(atas_pkg::QUEUE_DEPTH + 1);

    atas_pkg::t_job   r_mem [atas_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(atas_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(atas_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(atas_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from empty queue");

endmodule

`default_nettype wire

[rtl/atas_back.sv]
// Sample engine: sums harmonics through one shared multiplier, applies the
// envelope, saturates and holds the result in an output register. Uses atas_pkg, atas_if.
`timescale 1ns / 1ps
`default_nettype none

module atas_back #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int HARMONIC_COUNT   = 4,
    parameter int PHASE_BITS       = 24
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [63:0]    i_gains,
    input  wire atas_pkg::t_job i_job,
    input  wire logic           i_empty,
    output logic                o_pop,
    atas_out_if.source          o_out
);

    localparam int LOG_DEPTH = $clog2(SINE_TABLE_DEPTH);
    localparam int QDEPTH    = SINE_TABLE_DEPTH / 4;
    localparam int J_W       = LOG_DEPTH - 1;
    localparam int ACC_W     = atas_pkg::ACC_W;
    localparam int PROD_W    = atas_pkg::PROD_W;
    localparam int Q_W       = PROD_W - atas_pkg::FRAC_SHIFT;
    localparam logic [1:0] H_LAST = 2'(HARMONIC_COUNT - 1);

    logic [14:0] w_rom [QDEPTH+1];

    for (genvar gj = 0; gj <= QDEPTH; gj++) begin : g_rom
        assign w_rom[gj] = atas_pkg::sine_mag(13'(gj), 4'(LOG_DEPTH));
    end

    atas_pkg::t_back_state        r_state, n_state;
    logic [1:0]                   r_h;
    logic [PHASE_BITS-1:0]        r_base, r_ph;
    logic [atas_pkg::LEVEL_W-1:0] r_lvl;
    logic                         r_active, r_last;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_out_valid;
    logic signed [15:0]           r_out_sample;
    logic                         r_out_last, r_out_silent;

    logic [LOG_DEPTH-1:0]     w_idx;
    logic [1:0]               w_quad;
    logic [J_W-1:0]           w_j;
    logic [14:0]              w_mag;
    logic signed [15:0]       w_sine;
    logic signed [15:0]       w_gain;
    logic signed [31:0]       w_mac;
    logic signed [Q_W-1:0]    w_q;
    logic signed [Q_W:0]      w_t;
    logic signed [15:0]       w_sat;
    logic                     w_out_free;
    logic                     w_load_out;

    always_comb begin
        w_idx  = r_ph[PHASE_BITS-1 -: LOG_DEPTH];
        w_quad = w_idx[LOG_DEPTH-1 -: 2];
        w_j    = w_quad[0] ? J_W'(QDEPTH) - {1'b0, w_idx[LOG_DEPTH-3:0]}
                           : {1'b0, w_idx[LOG_DEPTH-3:0]};
        w_mag  = w_rom[w_j];
        w_sine = w_quad[1] ? -signed'({1'b0, w_mag}) : signed'({1'b0, w_mag});
        w_gain = signed'(i_gains[{r_h, 4'b0000} +: atas_pkg::GAIN_W]);
        w_mac  = w_gain * w_sine;
    end

    always_comb begin
        w_q = r_prod[PROD_W-1:atas_pkg::FRAC_SHIFT];
        w_t = {w_q[Q_W-1], w_q}
            + (Q_W+1)'(r_prod[PROD_W-1] && (|r_prod[atas_pkg::FRAC_SHIFT-1:0]));
        if (w_t > (Q_W+1)'(32767)) begin
            w_sat = 16'sd32767;
        end else if (w_t < -(Q_W+1)'(32768)) begin
            w_sat = -16'sd32768;
        end else begin
            w_sat = w_t[15:0];
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            atas_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = atas_pkg::BK_MAC;
                end
            end
            atas_pkg::BK_MAC: begin
                if (r_h == H_LAST) begin
                    n_state = atas_pkg::BK_MUL;
                end
            end
            atas_pkg::BK_MUL: begin
                n_state = atas_pkg::BK_FIN;
            end
            atas_pkg::BK_FIN: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    if (!i_empty) begin
                        o_pop   = 1'b1;
                        n_state = atas_pkg::BK_MAC;
                    end else begin
                        n_state = atas_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = atas_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atas_pkg::BK_IDLE;
            r_h         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_h <= '0;
            end else if (r_state == atas_pkg::BK_MAC) begin
                r_h <= r_h + 2'd1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_base   <= i_job.phase[PHASE_BITS-1:0];
            r_ph     <= i_job.phase[PHASE_BITS-1:0];
            r_lvl    <= i_job.level;
            r_active <= i_job.active;
            r_last   <= i_job.last;
            r_acc    <= '0;
        end else if (r_state == atas_pkg::BK_MAC) begin
            r_acc <= r_acc + {{(ACC_W-32){w_mac[31]}}, w_mac};
            r_ph  <= r_ph + r_base;
        end
        if (r_state == atas_pkg::BK_MUL) begin
            r_prod <= r_acc * signed'({1'b0, r_lvl});
        end
        if (w_load_out) begin
            r_out_sample <= r_active ? w_sat : 16'sd0;
            r_out_last   <= r_last;
            r_out_silent <= !r_active;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.sample    = r_out_sample;
    assign o_out.note_last = r_out_last;
    assign o_out.silent    = r_out_silent;

    a_mul_after_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atas_pkg::BK_MUL) |-> ($past(r_state) == atas_pkg::BK_MAC))
        else $error("envelope multiply not preceded by harmonic sum");
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_silent) |-> ((r_out_sample == 16'sd0) && !r_out_last))
        else $error("silent sample not zero or flagged last");

endmodule

`default_nettype wire
